// File: sv/isort_pkg.sv
`timescale 1ns / 1ps
// Shared types for the insertion sorter.
// No dependencies.
package isort_pkg;

	typedef logic signed [31:0] word_t;

	typedef struct packed {
		logic ins;
		logic shl;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		ST_FILL  = 2'b01,
		ST_DRAIN = 2'b10
	} state_t;

endpackage

// File: sv/isort_if.sv
`timescale 1ns / 1ps
// Valid/ready channels for the insertion sorter input and output words.
// Depends on isort_pkg.
interface isort_in_if;
	logic               valid;
	logic               ready;
	isort_pkg::word_t   value;
	logic               last;

	modport source (output valid, output value, output last, input ready);
	modport sink (input valid, input value, input last, output ready);
endinterface

interface isort_out_if;
	logic               valid;
	logic               ready;
	isort_pkg::word_t   sorted_value;
	logic               final_res;
	logic               overflow;

	modport source (output valid, output sorted_value, output final_res, output overflow,
		input ready);
	modport sink (input valid, input sorted_value, input final_res, input overflow,
		output ready);
endinterface

// File: sv/insertion_sorter.sv
`timescale 1ns / 1ps
// Insertion sorter: one input word per cycle while filling; a systolic row of cells
// inserts each value in sorted order. On the word marked last, input stalls and the
// set drains from cell 0, one result per cycle unless out.ready holds it; each result
// is registered in the output word register. Input is ready again the cycle after
// the final result is loaded. Reset (arst_n low) empties every cell and clears count
// and overflow. Depends on isort_pkg, isort_if, isort_cell.
module insertion_sorter #(
	parameter int CAPACITY = 32
) (
	input  logic  clk,
	input  logic  arst_n,
	isort_in_if.sink    in,
	isort_out_if.source out
);
	import isort_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);

	state_t        state_q;
	logic [CW-1:0] count_q;
	logic          flag_q;
	logic          out_valid_q;
	word_t         out_value_q;
	logic          out_final_q;
	logic          out_ovf_q;

	logic          accept;
	logic          full;
	logic          load;
	cell_ctl_t     ctl;

	word_t cell_value [CAPACITY];
	logic  cell_valid [CAPACITY];
	logic  cell_gt    [CAPACITY];

	assign full     = (count_q == CW'(CAPACITY));
	assign in.ready = (state_q == ST_FILL);
	assign accept   = in.valid && in.ready;
	assign load     = (state_q == ST_DRAIN) && (!out_valid_q || out.ready);
	assign ctl.ins  = accept && !full;
	assign ctl.shl  = load;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		word_t prev_value;
		logic  prev_gt;
		logic  prev_valid;
		word_t next_value;
		logic  next_valid;

		if (i == 0) begin : g_head
			assign prev_value = in.value;
			assign prev_gt    = 1'b0;
			assign prev_valid = 1'b1;
		end else begin : g_body
			assign prev_value = cell_value[i-1];
			assign prev_gt    = cell_gt[i-1];
			assign prev_valid = cell_valid[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign next_value = cell_value[i];
			assign next_valid = 1'b0;
		end else begin : g_mid
			assign next_value = cell_value[i+1];
			assign next_valid = cell_valid[i+1];
		end

		isort_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.ins_value  (in.value),
			.prev_value (prev_value),
			.prev_gt    (prev_gt),
			.prev_valid (prev_valid),
			.next_value (next_value),
			.next_valid (next_valid),
			.value      (cell_value[i]),
			.valid      (cell_valid[i]),
			.gt         (cell_gt[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
			count_q <= '0;
			flag_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_FILL: begin
					if (accept) begin
						if (full) begin
							flag_q <= 1'b1;
						end else begin
							count_q <= count_q + CW'(1);
						end
						if (in.last) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					if (load) begin
						count_q <= count_q - CW'(1);
						if (count_q == CW'(1)) begin
							flag_q  <= 1'b0;
							state_q <= ST_FILL;
						end
					end
				end
				default: begin
					state_q <= ST_FILL;
				end
			endcase
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_value_q <= cell_value[0];
			out_final_q <= (count_q == CW'(1));
			out_ovf_q   <= flag_q;
		end
	end

	assign out.valid        = out_valid_q;
	assign out.sorted_value = out_value_q;
	assign out.final_res    = out_final_q;
	assign out.overflow     = out_ovf_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("held count above capacity");

	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid[0] == (count_q != '0))
		else $error("cell 0 occupancy disagrees with count");

	a_drain_end: assert property (@(posedge clk) disable iff (!arst_n)
		(load && count_q == CW'(1)) |=> (in.ready && count_q == '0 && !flag_q))
		else $error("set not cleared after final word");

	a_no_empty_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> (count_q != '0))
		else $error("drain with empty store");

endmodule

// File: sv/isort_cell.sv
`timescale 1ns / 1ps
// One slot of the sorting chain: holds one value, inserts or shifts toward cell 0.
// Depends on isort_pkg.
module isort_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  isort_pkg::cell_ctl_t ctl,
	input  isort_pkg::word_t     ins_value,
	input  isort_pkg::word_t     prev_value,
	input  logic                 prev_gt,
	input  logic                 prev_valid,
	input  isort_pkg::word_t     next_value,
	input  logic                 next_valid,
	output isort_pkg::word_t     value,
	output logic                 valid,
	output logic                 gt
);
	import isort_pkg::*;

	word_t value_q;
	logic  valid_q;

	assign gt    = valid_q && (value_q > ins_value);
	assign value = value_q;
	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.shl) begin
			valid_q <= next_valid;
		end else if (ctl.ins && !valid_q && prev_valid) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shl) begin
			value_q <= next_value;
		end else if (ctl.ins) begin
			if (gt) begin
				value_q <= prev_gt ? prev_value : ins_value;
			end else if (!valid_q && prev_valid) begin
				// first empty slot takes the shifted word, or the new value if none shifts, when the row moves up
				value_q <= prev_gt ? prev_value : ins_value;
			end
		end
	end

endmodule
